FILE: sv/sipf_pkg.sv
`timescale 1ns / 1ps
package sipf_pkg;

	// mode codes
	localparam logic [1:0] MODE_PING  = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_WRITE = 2'd2;
	localparam logic [1:0] MODE_SYNC  = 2'd3;

	// protocol bytes
	localparam logic [7:0] SYNC_BYTE      = 8'hFF;
	localparam logic [7:0] BROADCAST_ID   = 8'hFE;
	localparam logic [7:0] INS_PING       = 8'h01;
	localparam logic [7:0] INS_READ       = 8'h02;
	localparam logic [7:0] INS_WRITE      = 8'h03;
	localparam logic [7:0] INS_SYNC_WRITE = 8'h83;
	localparam logic [7:0] MAX_DATA       = 8'd250;

	// header lengths in bytes, sync bytes included
	localparam logic [2:0] HDR_NONE  = 3'd0;
	localparam logic [2:0] HDR_PING  = 3'd5;
	localparam logic [2:0] HDR_WRITE = 3'd6;
	localparam logic [2:0] HDR_LONG  = 3'd7;

	// header byte positions
	localparam logic [2:0] POS_SYNC0 = 3'd0;
	localparam logic [2:0] POS_SYNC1 = 3'd1;
	localparam logic [2:0] POS_ID    = 3'd2;
	localparam logic [2:0] POS_LEN   = 3'd3;
	localparam logic [2:0] POS_INS   = 3'd4;
	localparam logic [2:0] POS_P0    = 3'd5;
	localparam logic [2:0] POS_P1    = 3'd6;

	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] servo_id;
		logic [7:0] address;
		logic [7:0] read_size;
		logic [7:0] data_count;
		logic [7:0] entry_length;
		logic [7:0] data_byte;
		logic       has_data;
		logic       first;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       end_of_packet;
	} pkt_t;

	// classified work for the back end: one entry per item that emits bytes
	typedef struct packed {
		logic [2:0] hdr_len;
		logic [7:0] id;
		logic [7:0] len;
		logic [7:0] ins;
		logic [7:0] p0;
		logic [7:0] p1;
		logic [7:0] data;
		logic       emit_data;
		logic       emit_cs;
	} entry_t;

endpackage

FILE: sv/sipf_front.sv
`timescale 1ns / 1ps
module sipf_front import sipf_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   cmd_valid,
	output logic   cmd_stall,
	input  cmd_t   cmd,
	input  logic   q_full,
	output logic   push,
	output entry_t push_entry
);

	logic       in_packet_q;
	logic       open;
	logic [7:0] count;
	logic       accept;

	// clamp the data count so the length byte never wraps
	assign count = (cmd.data_count > MAX_DATA) ? MAX_DATA : cmd.data_count;
	assign open  = cmd.first || in_packet_q;

	// classify the beat into header, data and checksum work
	always_comb begin
		push_entry           = '0;
		push_entry.data      = cmd.data_byte;
		push_entry.emit_data = cmd.has_data && open;
		push_entry.emit_cs   = cmd.last && open;
		push_entry.id        = cmd.servo_id;
		push_entry.p0        = cmd.address;
		if (cmd.first) begin
			case (cmd.mode)
				MODE_PING: begin
					push_entry.hdr_len = HDR_PING;
					push_entry.len     = 8'd2;
					push_entry.ins     = INS_PING;
				end
				MODE_READ: begin
					push_entry.hdr_len = HDR_LONG;
					push_entry.len     = 8'd4;
					push_entry.ins     = INS_READ;
					push_entry.p1      = cmd.read_size;
				end
				MODE_WRITE: begin
					push_entry.hdr_len = HDR_WRITE;
					push_entry.len     = 8'd3 + count;
					push_entry.ins     = INS_WRITE;
				end
				default: begin
					push_entry.hdr_len = HDR_LONG;
					push_entry.id      = BROADCAST_ID;
					push_entry.len     = 8'd4 + count;
					push_entry.ins     = INS_SYNC_WRITE;
					push_entry.p1      = cmd.entry_length;
				end
			endcase
		end else begin
			push_entry.hdr_len = HDR_NONE;
		end
	end

	assign cmd_stall = q_full;
	assign accept    = cmd_valid && !cmd_stall;
	// drop beats that emit nothing
	assign push      = accept && (cmd.first || push_entry.emit_data || push_entry.emit_cs);

	// track whether a packet is open
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_packet_q <= 1'b0;
		end else if (accept) begin
			if (cmd.first) begin
				in_packet_q <= !cmd.last;
			end else if (cmd.last) begin
				in_packet_q <= 1'b0;
			end
		end
	end

endmodule

FILE: sv/sipf_queue.sv
`timescale 1ns / 1ps
module sipf_queue import sipf_pkg::*; #(
	parameter int Depth = QUEUE_DEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   full,
	input  logic   pop,
	output logic   head_valid,
	output entry_t head
);

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	entry_t         mem_q [Depth];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign full       = (count_q == CW'(Depth));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: sv/sipf_back.sv
`timescale 1ns / 1ps
module sipf_back import sipf_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   head_valid,
	input  entry_t head,
	output logic   pop,
	output logic   pkt_valid,
	input  logic   pkt_stall,
	output pkt_t   pkt
);

	logic [3:0] pos_q;
	logic [7:0] sum_q;
	logic       pkt_valid_q;
	pkt_t       pkt_q;

	logic       advance;
	logic       in_hdr;
	logic       is_data;
	logic [3:0] hdr_end;
	logic [3:0] total;
	logic       last_step;
	logic [7:0] hdr_byte;
	logic [7:0] next_byte;

	assign hdr_end   = {1'b0, head.hdr_len};
	assign total     = hdr_end + {3'b0, head.emit_data} + {3'b0, head.emit_cs};
	assign in_hdr    = (pos_q < hdr_end);
	assign is_data   = !in_hdr && head.emit_data && (pos_q == hdr_end);
	assign last_step = (pos_q == total - 4'd1);

	// pick the header byte for this position
	always_comb begin
		case (pos_q[2:0])
			POS_SYNC0: hdr_byte = SYNC_BYTE;
			POS_SYNC1: hdr_byte = SYNC_BYTE;
			POS_ID:    hdr_byte = head.id;
			POS_LEN:   hdr_byte = head.len;
			POS_INS:   hdr_byte = head.ins;
			POS_P0:    hdr_byte = head.p0;
			POS_P1:    hdr_byte = head.p1;
			default:   hdr_byte = SYNC_BYTE;
		endcase
	end

	always_comb begin
		if (in_hdr) begin
			next_byte = hdr_byte;
		end else if (is_data) begin
			next_byte = head.data;
		end else begin
			next_byte = ~sum_q;
		end
	end

	assign advance = head_valid && (!pkt_valid_q || !pkt_stall);
	assign pop     = advance && last_step;

	// step through the entry, one byte per beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			sum_q       <= '0;
			pkt_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				pkt_valid_q <= 1'b1;
				pos_q       <= last_step ? 4'd0 : pos_q + 4'd1;
				if (in_hdr) begin
					if (pos_q[2:0] == POS_SYNC0) begin
						sum_q <= '0;
					end else if (pos_q[2:0] != POS_SYNC1) begin
						sum_q <= sum_q + hdr_byte;
					end
				end else if (is_data) begin
					sum_q <= sum_q + head.data;
				end else begin
					sum_q <= '0;
				end
			end else if (!pkt_stall) begin
				pkt_valid_q <= 1'b0;
			end
		end
	end

	// hold the output beat until taken
	always_ff @(posedge clk) begin
		if (advance) begin
			pkt_q.out_byte      <= next_byte;
			pkt_q.end_of_packet <= !in_hdr && !is_data;
		end
	end

	assign pkt_valid = pkt_valid_q;
	assign pkt       = pkt_q;

endmodule

FILE: sv/servo_instruction_packet_framer_core.sv
`timescale 1ns / 1ps
// Servo-bus instruction packet framer.
// Command channel (cmd_valid / cmd_stall / cmd): one beat per item. A beat with
// first set opens a packet and yields its header (5 bytes for ping, 6 for
// write, 7 for read and sync write); a beat with has_data inside a packet
// yields one parameter byte; a beat with last inside a packet yields the
// checksum, flagged by end_of_packet.
// Packet channel (pkt_valid / pkt_stall / pkt): one framed byte per beat.
// With the back end idle, the first byte of a beat passes through the queue and
// the output register before it is presented.
// Throughput: one output byte per cycle while pkt_stall is low, set by the
// single byte sequencer in the back end; data beats therefore flow one per
// cycle, while a header beat occupies the sequencer for its header, plus a
// data byte and the checksum when it carries them, and the command channel
// stalls once the Depth-entry queue between front and back fills.
// Reset clears the open-packet flag, the checksum, the queue and the output
// valid; no clearing pass is needed. When the receiver stalls, the output
// byte holds, the sequencer waits, and the queue absorbs up to Depth beats
// before cmd_stall rises.
module servo_instruction_packet_framer_core import sipf_pkg::*; #(
	parameter int Depth = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic pkt_valid,
	input  logic pkt_stall,
	output pkt_t pkt
);

	logic   q_full;
	logic   push;
	entry_t push_entry;
	logic   pop;
	logic   head_valid;
	entry_t head;

	// classify incoming beats
	sipf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	// decouple front and back
	sipf_queue #(
		.Depth (Depth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// emit bytes and checksum
	sipf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.pkt_valid  (pkt_valid),
		.pkt_stall  (pkt_stall),
		.pkt        (pkt)
	);

endmodule
